[hdl/prpz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpz_pkg: shared definitions for the point projection core
// Widths, register indexes, request codes and helper types used by the
// projection datapath, its shared multiplier and its iterative divider.
// ----------------------------------------------------------------------------
package prpz_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  localparam int STORE_DEPTH = 8192;
  localparam int STORE_AW    = 13;
  localparam int SYM_W       = 8;
  localparam int DEPTH_W     = 24;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int NUM_W   = 64;

  localparam logic [SYM_W-1:0]   SYM_SPACE   = 8'd32;
  localparam logic [DEPTH_W-1:0] DEPTH_FAR   = 24'hFFFFFF;
  localparam logic [DEPTH_W-1:0] DEPTH_MAXKEY = 24'hFFFFFE;
  localparam logic signed [NUM_W-1:0] NEAR_LIMIT = 64'sd112589990684262;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam logic [2:0] CFG_SIN_A    = 3'd0;
  localparam logic [2:0] CFG_COS_A    = 3'd1;
  localparam logic [2:0] CFG_SIN_B    = 3'd2;
  localparam logic [2:0] CFG_COS_B    = 3'd3;
  localparam logic [2:0] CFG_SIN_C    = 3'd4;
  localparam logic [2:0] CFG_COS_C    = 3'd5;
  localparam logic [2:0] CFG_CAM_DIST = 3'd6;
  localparam logic [2:0] CFG_SCALE    = 3'd7;

  typedef enum logic [1:0] {
    REQ_PLOT  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef struct packed {
    logic done;
    logic ok;
  } div_status_t;

  function automatic logic signed [15:0] sat_trig(input logic [15:0] v);
    logic signed [15:0] s;
    s = $signed(v);
    if (s > ONE_Q14) begin
      return ONE_Q14;
    end else if (s < -ONE_Q14) begin
      return -ONE_Q14;
    end
    return s;
  endfunction

endpackage

[hdl/point_rotate_project_zbuffer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_project_zbuffer_core: rotate, project and depth-test points
// Rotates a point with preloaded sine and cosine registers, projects it onto
// the screen and keeps the nearest symbol per cell in a depth-tested store.
// ----------------------------------------------------------------------------
// Requests arrive on the in_valid_i / in_stall_o channel and each one gives
// exactly one result on the out_valid_o / out_stall_i channel. A plot request
// rotates the point with twelve products through one shared multiplier, forms
// both projection numerators with four more, divides each by the depth in an
// iterative divider one quotient bit a cycle, then reads and compares the depth
// store and writes both stores if the point is nearer. A point behind the near
// plane ends after the rotation. A clear request sweeps both stores one cell a
// cycle. After reset the same sweep runs before the first request is taken;
// configuration writes are taken at any time. One request is in work at a
// time and in_stall_o stays high while it is. A finished result waits in the
// output register while the receiver stalls, and the next request is taken
// meanwhile; it finishes only once that result is gone.
// ----------------------------------------------------------------------------
module point_rotate_project_zbuffer_core import prpz_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic signed [15:0]  point_x_i,
  input  logic signed [15:0]  point_y_i,
  input  logic signed [15:0]  point_z_i,
  input  logic [7:0]          face_symbol_i,
  input  logic [12:0]         cell_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          cell_symbol_o,
  output logic                was_written_o
);

  localparam int XB     = $clog2(SCREEN_WIDTH);
  localparam int YB     = $clog2(SCREEN_HEIGHT);
  localparam int QB     = (XB > YB) ? XB : YB;
  localparam int QW     = QB + 1;
  localparam int IDX_W  = XB + YB;
  localparam logic signed [MUL_B_W-1:0] HALF_W = MUL_B_W'(SCREEN_WIDTH / 2);
  localparam logic signed [MUL_B_W-1:0] HALF_H = MUL_B_W'(SCREEN_HEIGHT / 2);
  localparam logic [QW-1:0] LIM_W = QW'(SCREEN_WIDTH);
  localparam logic [QW-1:0] LIM_H = QW'(SCREEN_HEIGHT);

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_CLEAR  = 11'b000_0000_0010,
    ST_ROT    = 11'b000_0000_0100,
    ST_DIVX   = 11'b000_0000_1000,
    ST_DIVY   = 11'b000_0001_0000,
    ST_IDXC   = 11'b000_0010_0000,
    ST_LOOK   = 11'b000_0100_0000,
    ST_CMP    = 11'b000_1000_0000,
    ST_READ   = 11'b001_0000_0000,
    ST_RDATA  = 11'b010_0000_0000,
    ST_FINISH = 11'b100_0000_0000
  } state_e;

  state_e                  state_q, state_d;
  logic [4:0]              step_q;
  logic [STORE_AW-1:0]     clr_cnt_q;
  logic                    init_q;
  logic                    out_valid_q;
  logic [15:0]             cfg_q [8];

  logic signed [15:0]      x_q, y_q, z_q;
  logic [SYM_W-1:0]        sym_q;
  logic [STORE_AW-1:0]     cell_q;
  logic signed [31:0]      y1_q, z1_q;
  logic signed [47:0]      x2_q, z2_q;
  logic signed [63:0]      x3_q, y3_q;
  logic signed [34:0]      zq_q, xq_q, yq_q;
  logic [DEPTH_W-1:0]      key_q;
  logic signed [NUM_W-1:0] numx_q, numy_q;
  logic [XB-1:0]           sx_q;
  logic [YB-1:0]           sy_q;
  logic [STORE_AW-1:0]     idx_q;
  logic [SYM_W-1:0]        res_sym_q, out_sym_q;
  logic                    res_wr_q, out_wr_q;

  logic signed [15:0]      sa, ca, sb, cb, sc, cc;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [63:0]      p;
  logic signed [63:0]      rz;
  logic [26:0]             key_wide;
  logic [DEPTH_W-1:0]      key_d;
  logic [IDX_W-1:0]        idx_full;
  logic [31:0]             idx_ext;

  logic                    accept;
  logic                    load_out;
  logic                    div_start;
  logic signed [NUM_W-1:0] div_num;
  logic signed [NUM_W-1:0] div_den;
  logic [QW-1:0]           div_lim;
  div_status_t             div_st;
  logic [QW-1:0]           div_q;

  logic                    win;
  logic                    ram_we;
  logic [STORE_AW-1:0]     ram_waddr;
  logic [STORE_AW-1:0]     ram_raddr;
  logic [SYM_W-1:0]        sym_wdata, sym_rdata;
  logic [DEPTH_W-1:0]      dep_wdata, dep_rdata;

  assign sa = sat_trig(cfg_q[CFG_SIN_A]);
  assign ca = sat_trig(cfg_q[CFG_COS_A]);
  assign sb = sat_trig(cfg_q[CFG_SIN_B]);
  assign cb = sat_trig(cfg_q[CFG_COS_B]);
  assign sc = sat_trig(cfg_q[CFG_SIN_C]);
  assign cc = sat_trig(cfg_q[CFG_COS_C]);

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign load_out   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  assign p  = mul_p[63:0];
  assign rz = $signed({{2{z2_q[47]}}, z2_q, 14'b0})
            + $signed({6'b0, cfg_q[CFG_CAM_DIST], 42'b0});
  assign key_wide = rz[62:36];
  assign key_d    = (key_wide > 27'(DEPTH_MAXKEY)) ? DEPTH_MAXKEY : key_wide[DEPTH_W-1:0];

  assign idx_full = IDX_W'(sy_q) * IDX_W'(SCREEN_WIDTH) + IDX_W'(sx_q);
  assign idx_ext  = 32'(idx_full);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      5'd0:  begin mul_a = MUL_A_W'(y_q); mul_b = MUL_B_W'(ca); end
      5'd1:  begin mul_a = MUL_A_W'(z_q); mul_b = MUL_B_W'(sa); end
      5'd2:  begin mul_a = MUL_A_W'(y_q); mul_b = MUL_B_W'(sa); end
      5'd3:  begin mul_a = MUL_A_W'(z_q); mul_b = MUL_B_W'(ca); end
      5'd4:  begin mul_a = $signed({{18{x_q[15]}}, x_q, 14'b0}); mul_b = MUL_B_W'(cb); end
      5'd5:  begin mul_a = $signed({{18{x_q[15]}}, x_q, 14'b0}); mul_b = MUL_B_W'(sb); end
      5'd6:  begin mul_a = MUL_A_W'(z1_q); mul_b = MUL_B_W'(sb); end
      5'd7:  begin mul_a = MUL_A_W'(z1_q); mul_b = MUL_B_W'(cb); end
      5'd8:  begin mul_a = $signed({{2{y1_q[31]}}, y1_q, 14'b0}); mul_b = MUL_B_W'(sc); end
      5'd9:  begin mul_a = $signed({{2{y1_q[31]}}, y1_q, 14'b0}); mul_b = MUL_B_W'(cc); end
      5'd10: begin mul_a = x2_q; mul_b = MUL_B_W'(cc); end
      5'd11: begin mul_a = x2_q; mul_b = MUL_B_W'(sc); end
      5'd14: begin mul_a = MUL_A_W'(zq_q); mul_b = HALF_W; end
      5'd15: begin mul_a = MUL_A_W'(xq_q); mul_b = $signed({1'b0, cfg_q[CFG_SCALE]}); end
      5'd16: begin mul_a = MUL_A_W'(zq_q); mul_b = HALF_H; end
      5'd17: begin mul_a = MUL_A_W'(yq_q); mul_b = $signed({1'b0, cfg_q[CFG_SCALE]}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  prpz_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign div_start = ((state_q == ST_ROT) && (step_q == 5'd18))
                   || ((state_q == ST_DIVX) && div_st.done && div_st.ok);
  assign div_num   = (state_q == ST_ROT) ? numx_q : numy_q;
  assign div_lim   = (state_q == ST_ROT) ? LIM_W : LIM_H;
  assign div_den   = $signed({{21{zq_q[34]}}, zq_q, 8'b0});

  prpz_div #(
    .QW (QW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .lim_i    (div_lim),
    .status_o (div_st),
    .q_o      (div_q)
  );

  assign win       = (state_q == ST_CMP) && (key_q < dep_rdata);
  assign ram_we    = (state_q == ST_CLEAR) || win;
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : idx_q;
  assign ram_raddr = (state_q == ST_READ) ? cell_q : idx_q;
  assign sym_wdata = (state_q == ST_CLEAR) ? SYM_SPACE : sym_q;
  assign dep_wdata = (state_q == ST_CLEAR) ? DEPTH_FAR : key_q;

  prpz_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STORE_DEPTH)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sym_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (sym_rdata)
  );

  prpz_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (STORE_DEPTH)
  ) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (dep_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (dep_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_e'(req_type_i))
            REQ_PLOT:  state_d = ST_ROT;
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_READ:  state_d = ST_READ;
            default:   state_d = ST_FINISH;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_q == STORE_AW'(STORE_DEPTH - 1)) begin
          state_d = init_q ? ST_IDLE : ST_FINISH;
        end
      end
      ST_ROT: begin
        if ((step_q == 5'd13) && (rz <= NEAR_LIMIT)) begin
          state_d = ST_FINISH;
        end else if (step_q == 5'd18) begin
          state_d = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (div_st.done) begin
          state_d = div_st.ok ? ST_DIVY : ST_FINISH;
        end
      end
      ST_DIVY: begin
        if (div_st.done) begin
          state_d = div_st.ok ? ST_IDXC : ST_FINISH;
        end
      end
      ST_IDXC: begin
        state_d = (idx_ext < 32'(STORE_DEPTH)) ? ST_LOOK : ST_FINISH;
      end
      ST_LOOK:  state_d = ST_CMP;
      ST_CMP:   state_d = ST_FINISH;
      ST_READ:  state_d = ST_RDATA;
      ST_RDATA: state_d = ST_FINISH;
      ST_FINISH: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      clr_cnt_q   <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
      cfg_q[CFG_SIN_A]    <= 16'd0;
      cfg_q[CFG_COS_A]    <= 16'd16384;
      cfg_q[CFG_SIN_B]    <= 16'd0;
      cfg_q[CFG_COS_B]    <= 16'd16384;
      cfg_q[CFG_SIN_C]    <= 16'd0;
      cfg_q[CFG_COS_C]    <= 16'd16384;
      cfg_q[CFG_CAM_DIST] <= 16'd25600;
      cfg_q[CFG_SCALE]    <= 16'd7680;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
      if (accept) begin
        step_q    <= '0;
        clr_cnt_q <= '0;
      end else if (state_q == ST_ROT) begin
        step_q <= step_q + 1'b1;
      end
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == STORE_AW'(STORE_DEPTH - 1)) begin
          init_q <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q       <= point_x_i;
      y_q       <= point_y_i;
      z_q       <= point_z_i;
      sym_q     <= face_symbol_i;
      cell_q    <= cell_index_i;
      res_sym_q <= '0;
      res_wr_q  <= 1'b0;
    end
    if (state_q == ST_ROT) begin
      case (step_q)
        5'd1:  y1_q <= p[31:0];
        5'd2:  y1_q <= y1_q - p[31:0];
        5'd3:  z1_q <= p[31:0];
        5'd4:  z1_q <= z1_q + p[31:0];
        5'd5:  x2_q <= p[47:0];
        5'd6:  z2_q <= -p[47:0];
        5'd7:  x2_q <= x2_q + p[47:0];
        5'd8:  z2_q <= z2_q + p[47:0];
        5'd9:  x3_q <= -p;
        5'd10: y3_q <= p;
        5'd11: x3_q <= x3_q + p;
        5'd12: y3_q <= y3_q + p;
        5'd13: begin
          zq_q  <= rz[60:26];
          xq_q  <= x3_q[60:26];
          yq_q  <= y3_q[60:26];
          key_q <= key_d;
        end
        5'd15: numx_q <= $signed({p[55:0], 8'b0});
        5'd16: numx_q <= numx_q + $signed({p[62:0], 1'b0});
        5'd17: numy_q <= $signed({p[55:0], 8'b0});
        5'd18: numy_q <= numy_q - p;
        default: ;
      endcase
    end
    if ((state_q == ST_DIVX) && div_st.done) begin
      sx_q <= div_q[XB-1:0];
    end
    if ((state_q == ST_DIVY) && div_st.done) begin
      sy_q <= div_q[YB-1:0];
    end
    if (state_q == ST_IDXC) begin
      idx_q <= idx_ext[STORE_AW-1:0];
    end
    if (win) begin
      res_wr_q <= 1'b1;
    end
    if (state_q == ST_RDATA) begin
      res_sym_q <= sym_rdata;
    end
    if (load_out) begin
      out_sym_q <= res_sym_q;
      out_wr_q  <= res_wr_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_symbol_o = out_sym_q;
  assign was_written_o = out_wr_q;

endmodule

[hdl/prpz_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpz_ram: generic single write port, single read port memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prpz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/prpz_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpz_mul: shared signed multiplier
// Registered signed product used for rotation and projection in turn.
// ----------------------------------------------------------------------------
module prpz_mul import prpz_pkg::*; (
  input  logic                       clk_i,
  input  logic signed [MUL_A_W-1:0]  a_i,
  input  logic signed [MUL_B_W-1:0]  b_i,
  output logic signed [MUL_P_W-1:0]  p_o
);

  logic signed [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[hdl/prpz_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpz_div: iterative restoring divider with screen range check
// Produces a truncated quotient one bit a cycle and flags whether it lies
// inside the screen, including the overflow bit as the top quotient bit.
// ----------------------------------------------------------------------------
module prpz_div import prpz_pkg::*; #(
  parameter int QW = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [NUM_W-1:0]  num_i,
  input  logic signed [NUM_W-1:0]  den_i,
  input  logic [QW-1:0]            lim_i,
  output div_status_t              status_o,
  output logic [QW-1:0]            q_o
);

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic                    busy_q;
  logic                    done_q;
  logic                    ok_q;
  logic [CW-1:0]           cnt_q;
  logic signed [NUM_W-1:0] rem_q;
  logic signed [NUM_W-1:0] dsh_q;
  logic [QW-1:0]           q_q;
  logic [QW-1:0]           lim_q;
  logic                    ge;
  logic [QW-1:0]           q_d;
  logic signed [NUM_W-1:0] neg_sum;

  assign ge      = (rem_q >= dsh_q);
  assign q_d     = {q_q[QW-2:0], ge};
  assign neg_sum = num_i + den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (num_i[NUM_W-1]) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(QW - 1);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lim_q <= lim_i;
      q_q   <= '0;
      rem_q <= num_i;
      dsh_q <= den_i <<< (QW - 1);
      ok_q  <= !neg_sum[NUM_W-1] && (neg_sum != '0);
    end else if (busy_q) begin
      q_q   <= q_d;
      dsh_q <= dsh_q >>> 1;
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      if (cnt_q == '0) begin
        ok_q <= (q_d < lim_q);
      end
    end
  end

  assign status_o.done = done_q;
  assign status_o.ok   = ok_q;
  assign q_o           = q_q;

endmodule
